@@ src/mlgi_pkg.sv @@
package mlgi_pkg;

	localparam int MaxDims       = 5;
	localparam int MaxGridPoints = 16;
	localparam int GridDepth     = MaxDims * MaxGridPoints;
	localparam int TableDepth    = 65536;

	// input item kinds
	localparam logic [1:0] KIND_GRID  = 2'd0;
	localparam logic [1:0] KIND_TABLE = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_DIM_COUNT = 3'd0;
	localparam logic [2:0] CFG_PTS_FIRST = 3'd1;
	localparam logic [2:0] CFG_PTS_LAST  = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE, S_G0, S_G1, S_GCHK, S_DIV, S_X0, S_X1, S_XCHK,
		S_CA, S_TRD, S_TV, S_PUSH, S_BWAIT, S_OUT
	} mlgi_state_t;

	typedef enum logic [2:0] {
		BL_IDLE, BL_MUL, BL_SUM, BL_DIV, BL_FIN
	} blend_phase_t;

	// one linear blend: f0 + (c - x0) * (f1 - f0) / (x1 - x0)
	typedef struct packed {
		logic signed [31:0] c;
		logic signed [31:0] x0;
		logic signed [31:0] x1;
		logic signed [31:0] f0;
		logic signed [31:0] f1;
	} blend_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [31:0] value;
		logic               sat;
	} blend_rsp_t;

	function automatic logic [2:0] dims_clamp(input logic [2:0] v);
		if (v == 3'd0)
			return 3'd1;
		else if (v > 3'(MaxDims))
			return 3'(MaxDims);
		else
			return v;
	endfunction

	function automatic logic [4:0] pts_clamp(input logic [4:0] v);
		if (v < 5'd2)
			return 5'd2;
		else if (v > 5'(MaxGridPoints))
			return 5'(MaxGridPoints);
		else
			return v;
	endfunction

endpackage

@@ src/mlgi_blend.sv @@
// Sequential linear blend: 32x32 multiply, cross-term add, then a
// restoring divide one quotient bit per cycle, saturating result.
module mlgi_blend
	import mlgi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  blend_req_t req,
	output blend_rsp_t rsp
);

	localparam int ProdW = 66;

	blend_phase_t       ph_q, ph_d;
	logic [32:0]        a_q, b_q, den_q;
	logic               neg_q;
	logic signed [31:0] f0_q;
	logic [63:0]        p0_s1;
	logic [ProdW-1:0]   prod_q;
	logic [6:0]         cnt_q;
	logic [32:0]        r_q;
	logic [40:0]        q_q;
	logic               big_q;
	logic               done_q;
	logic signed [31:0] val_q;
	logic               sat_q;

	logic signed [32:0] dt, df;
	logic [ProdW-1:0]   t1, t2, t3;
	logic [33:0]        rs;
	logic               ge;
	logic [42:0]        mag;
	logic signed [42:0] f0e, sum;

	// operand setup
	assign dt = {req.c[31], req.c} - {req.x0[31], req.x0};
	assign df = {req.f1[31], req.f1} - {req.f0[31], req.f0};

	// cross terms of the 33-bit magnitudes
	assign t1 = a_q[32] ? {2'b00, b_q[31:0], 32'd0} : '0;
	assign t2 = b_q[32] ? {2'b00, a_q[31:0], 32'd0} : '0;
	assign t3 = (a_q[32] & b_q[32]) ? {2'b01, 64'd0} : '0;

	// divide step
	assign rs = {r_q, prod_q[cnt_q]};
	assign ge = rs >= {1'b0, den_q};

	// final add and saturation; a huge quotient is held at 2^40
	assign mag = big_q ? 43'h100_0000_0000 : {2'b00, q_q};
	assign f0e = 43'(f0_q);
	assign sum = neg_q ? f0e - $signed(mag) : f0e + $signed(mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= BL_IDLE;
			done_q <= 1'b0;
		end else begin
			ph_q   <= ph_d;
			done_q <= (ph_q == BL_FIN);
		end
	end

	always_comb begin
		ph_d = ph_q;
		case (ph_q)
			BL_IDLE: if (start) ph_d = BL_MUL;
			BL_MUL:  ph_d = BL_SUM;
			BL_SUM:  ph_d = BL_DIV;
			BL_DIV:  if (cnt_q == 7'd0) ph_d = BL_FIN;
			BL_FIN:  ph_d = BL_IDLE;
			default: ph_d = BL_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (ph_q)
			BL_IDLE: begin
				if (start) begin
					a_q   <= dt[32] ? 33'(-dt) : 33'(dt);
					b_q   <= df[32] ? 33'(-df) : 33'(df);
					den_q <= 33'({req.x1[31], req.x1} - {req.x0[31], req.x0});
					neg_q <= dt[32] ^ df[32];
					f0_q  <= req.f0;
				end
			end
			BL_MUL: p0_s1 <= a_q[31:0] * b_q[31:0];
			BL_SUM: begin
				prod_q <= {2'b00, p0_s1} + t1 + t2 + t3;
				cnt_q  <= 7'(ProdW - 1);
				r_q    <= '0;
				q_q    <= '0;
				big_q  <= 1'b0;
			end
			BL_DIV: begin
				r_q   <= ge ? 33'(rs - {1'b0, den_q}) : rs[32:0];
				q_q   <= {q_q[39:0], ge};
				big_q <= big_q | q_q[39];
				cnt_q <= cnt_q - 7'd1;
			end
			BL_FIN: begin
				if (sum > 43'sd2147483647) begin
					val_q <= 32'sh7FFF_FFFF;
					sat_q <= 1'b1;
				end else if (sum < -43'sd2147483648) begin
					val_q <= 32'sh8000_0000;
					sat_q <= 1'b1;
				end else begin
					val_q <= sum[31:0];
					sat_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign rsp.busy  = (ph_q != BL_IDLE);
	assign rsp.done  = done_q;
	assign rsp.value = val_q;
	assign rsp.sat   = sat_q;

	a_div_ends_in_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == BL_DIV && cnt_q == 7'd0) |=> ph_q == BL_FIN)
		else $error("divide did not finish");
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(ph_q) == BL_FIN)
		else $error("done without finish");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ph_q == BL_IDLE)
		else $error("blend started while busy");

endmodule

@@ src/multilinear_grid_interpolator.sv @@
// Load beats (grid coordinate, table value) are accepted back to back while no query runs.
// A query of D dims finds a lower grid index k (0..14) in each dimension, then
// runs 2^D - 1 blends, each with a 66-step serial divide.
// Queries run one at a time; input is held off until the result reaches the output.
// Reset clears control and config registers; the memories need no clearing.
module multilinear_grid_interpolator
	import mlgi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [2:0]         dim_select,
	input  logic [3:0]         grid_index,
	input  logic [15:0]        table_address,
	input  logic signed [31:0] data_value,
	input  logic signed [31:0] coord_1,
	input  logic signed [31:0] coord_2,
	input  logic signed [31:0] coord_3,
	input  logic signed [31:0] coord_4,
	input  logic signed [31:0] coord_5,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [4:0]         cfg_data
);

	mlgi_state_t        state_q, state_d;
	logic [2:0]         dim_count_q;
	logic [4:0]         pts_q [MaxDims];

	logic signed [31:0] grid_mem [GridDepth];
	logic signed [31:0] tbl_mem [TableDepth];
	logic signed [31:0] grid_rd_q, tbl_rd_q;
	logic [6:0]         grid_ra;
	logic [15:0]        tbl_ra;

	logic signed [31:0] crd_q  [MaxDims];
	logic [3:0]         lo_q   [MaxDims];
	logic signed [31:0] xlo_q  [MaxDims];
	logic signed [31:0] xhi_q  [MaxDims];
	logic signed [31:0] slot_q [MaxDims];
	logic [MaxDims-1:0] have_q;

	logic [2:0]         nd_q, d_q, ad_q, lvl_q;
	logic signed [31:0] g0_q;
	logic [32:0]        rem_q, dx_q;
	logic [3:0]         k_q;
	logic [4:0]         corner_q;
	logic [15:0]        addr_q;
	logic signed [31:0] val_q, res_q;
	logic               bad_q, sat_seen_q;
	logic               out_valid_q;
	logic signed [31:0] out_val_q;
	logic [1:0]         out_st_q;

	logic               in_acc;
	logic [3:0]         lim;
	logic signed [32:0] dx, num, xd;
	logic               dx_bad, x_bad, div_go, last_dim, out_free;
	logic [2:0]         cidx;
	logic [15:0]        addr_n;
	logic               blend_start;
	blend_req_t         breq;
	blend_rsp_t         brsp;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= 3'd1;
			for (int i = 0; i < MaxDims; i++) pts_q[i] <= 5'd2;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_DIM_COUNT)
				dim_count_q <= cfg_data[2:0];
			else if (cfg_index >= CFG_PTS_FIRST && cfg_index <= CFG_PTS_LAST)
				pts_q[3'(cfg_index - CFG_PTS_FIRST)] <= cfg_data;
		end
	end

	// memories: write on load beats, registered read
	always_ff @(posedge clk) begin
		if (in_acc && kind == KIND_GRID && dim_select < 3'(MaxDims))
			grid_mem[7'({dim_select, grid_index})] <= data_value;
		grid_rd_q <= grid_mem[grid_ra];
	end

	always_ff @(posedge clk) begin
		if (in_acc && kind == KIND_TABLE)
			tbl_mem[table_address] <= data_value;
		tbl_rd_q <= tbl_mem[tbl_ra];
	end

	// shared arithmetic
	assign lim      = 4'(pts_clamp(pts_q[d_q]) - 5'd2);
	assign dx       = {grid_rd_q[31], grid_rd_q} - {g0_q[31], g0_q};
	assign num      = {crd_q[d_q][31], crd_q[d_q]} - {g0_q[31], g0_q};
	assign xd       = {grid_rd_q[31], grid_rd_q} - {xlo_q[d_q][31], xlo_q[d_q]};
	assign dx_bad   = dx[32] || dx == 33'sd0;
	assign x_bad    = xd[32] || xd == 33'sd0;
	assign div_go   = (k_q < lim) && (rem_q >= dx_q);
	assign last_dim = (d_q == 3'(nd_q - 3'd1));
	assign cidx     = 3'(nd_q - 3'd1 - ad_q);
	// Horner step of the corner's flat address, wraps at the table depth
	assign addr_n   = 16'(addr_q * {11'd0, pts_clamp(pts_q[ad_q])})
	                + {12'd0, lo_q[ad_q]} + {15'd0, corner_q[cidx]};

	assign breq.c  = crd_q[lvl_q];
	assign breq.x0 = xlo_q[lvl_q];
	assign breq.x1 = xhi_q[lvl_q];
	assign breq.f0 = slot_q[lvl_q];
	assign breq.f1 = val_q;

	mlgi_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.req    (breq),
		.rsp    (brsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state, memory addresses, blend launch
	always_comb begin
		state_d     = state_q;
		grid_ra     = '0;
		tbl_ra      = addr_q;
		blend_start = 1'b0;
		case (state_q)
			S_IDLE: if (in_acc && kind == KIND_QUERY) state_d = S_G0;
			S_G0: begin
				grid_ra = {d_q, 4'd0};
				state_d = S_G1;
			end
			S_G1: begin
				grid_ra = {d_q, 4'd1};
				state_d = S_GCHK;
			end
			S_GCHK:  state_d = dx_bad ? S_OUT : S_DIV;
			S_DIV:   if (!div_go) state_d = S_X0;
			S_X0: begin
				grid_ra = {d_q, k_q};
				state_d = S_X1;
			end
			S_X1: begin
				grid_ra = {d_q, 4'(k_q + 4'd1)};
				state_d = S_XCHK;
			end
			S_XCHK: begin
				if (x_bad)
					state_d = S_OUT;
				else if (last_dim)
					state_d = S_CA;
				else
					state_d = S_G0;
			end
			S_CA:    if (ad_q == 3'(nd_q - 3'd1)) state_d = S_TRD;
			S_TRD:   state_d = S_TV;
			S_TV:    state_d = S_PUSH;
			S_PUSH: begin
				if (have_q[lvl_q]) begin
					blend_start = 1'b1;
					state_d     = S_BWAIT;
				end else begin
					state_d = S_CA;
				end
			end
			S_BWAIT: begin
				if (brsp.done)
					state_d = (lvl_q == 3'd0) ? S_OUT : S_PUSH;
			end
			S_OUT:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// query control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= '0;
			bad_q       <= 1'b0;
			sat_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded from S_OUT, held until taken
			out_valid_q <= (state_q == S_OUT && out_free) || (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (in_acc && kind == KIND_QUERY) begin
						have_q     <= '0;
						bad_q      <= 1'b0;
						sat_seen_q <= 1'b0;
					end
				end
				S_GCHK:  if (dx_bad) bad_q <= 1'b1;
				S_XCHK:  if (x_bad) bad_q <= 1'b1;
				S_PUSH:  have_q[lvl_q] <= !have_q[lvl_q];
				S_BWAIT: if (brsp.done && brsp.sat) sat_seen_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && kind == KIND_QUERY) begin
					crd_q[0] <= coord_1;
					crd_q[1] <= coord_2;
					crd_q[2] <= coord_3;
					crd_q[3] <= coord_4;
					crd_q[4] <= coord_5;
					nd_q     <= dims_clamp(dim_count_q);
					d_q      <= 3'd0;
				end
			end
			S_G1: g0_q <= grid_rd_q;
			S_GCHK: begin
				dx_q  <= dx;
				rem_q <= num[32] ? 33'd0 : num;
				k_q   <= 4'd0;
			end
			S_DIV: begin
				if (div_go) begin
					rem_q <= rem_q - dx_q;
					k_q   <= k_q + 4'd1;
				end else begin
					lo_q[d_q] <= k_q;
				end
			end
			S_X1: xlo_q[d_q] <= grid_rd_q;
			S_XCHK: begin
				xhi_q[d_q] <= grid_rd_q;
				if (last_dim) begin
					corner_q <= 5'd0;
					ad_q     <= 3'd0;
					addr_q   <= 16'd0;
				end else begin
					d_q <= d_q + 3'd1;
				end
			end
			S_CA: begin
				addr_q <= addr_n;
				ad_q   <= ad_q + 3'd1;
			end
			S_TV: begin
				val_q <= tbl_rd_q;
				lvl_q <= 3'(nd_q - 3'd1);
			end
			S_PUSH: begin
				if (!have_q[lvl_q]) begin
					slot_q[lvl_q] <= val_q;
					corner_q      <= corner_q + 5'd1;
					ad_q          <= 3'd0;
					addr_q        <= 16'd0;
				end
			end
			S_BWAIT: begin
				if (brsp.done) begin
					if (lvl_q == 3'd0) begin
						res_q <= brsp.value;
					end else begin
						val_q <= brsp.value;
						lvl_q <= lvl_q - 3'd1;
					end
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_val_q <= bad_q ? 32'sd0 : res_q;
					out_st_q  <= bad_q ? ST_BAD : (sat_seen_q ? ST_SAT : ST_OK);
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_val_q;
	assign status       = out_st_q;

	a_blend_idle_at_rest: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !brsp.busy)
		else $error("blend unit busy while idle");
	a_blend_starts: assert property (@(posedge clk) disable iff (!arst_n)
		blend_start |=> brsp.busy)
		else $error("blend launch lost");
	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_BAD) |-> result_value == 32'sd0)
		else $error("bad spacing result not zero");

endmodule
